/* rtl/tcsr_pkg.sv */
// tcsr_pkg: shared types and constants of the terrain column span renderer
// depends on nothing; every rtl file but tcsr_ram refers to it by scoped names
package tcsr_pkg;

   // default sizes
   localparam int COLUMNS_DEFAULT   = 256;
   localparam int OUT_DEPTH_DEFAULT = 32;

   // register indexes on the configuration port
   localparam logic [2:0] CSR_CAMERA_HEIGHT = 3'd0;
   localparam logic [2:0] CSR_HORIZON_ROW   = 3'd1;
   localparam logic [2:0] CSR_SCREEN_HEIGHT = 3'd2;
   localparam logic [2:0] CSR_HEIGHT_SCALE  = 3'd3;
   localparam logic [2:0] CSR_MAX_DISTANCE  = 3'd4;
   localparam logic [2:0] CSR_HAZE_COLOR    = 3'd5;

   // register reset values
   localparam logic [11:0] CAMERA_HEIGHT_RESET = 12'd0;
   localparam logic [10:0] HORIZON_ROW_RESET   = 11'd120;
   localparam logic [9:0]  SCREEN_HEIGHT_RESET = 10'd240;
   localparam logic [7:0]  HEIGHT_SCALE_RESET  = 8'd70;
   localparam logic [9:0]  MAX_DISTANCE_RESET  = 10'd400;
   localparam logic [23:0] HAZE_COLOR_RESET    = 24'hC8C8FF;

   // saturation bounds of the projected row
   localparam logic [11:0] ROW_MIN = 12'h800;
   localparam logic [11:0] ROW_MAX = 12'h7FF;

   // configuration register set
   typedef struct packed {
      logic [11:0] camera_height;
      logic [10:0] horizon_row;
      logic [9:0]  screen_height;
      logic [7:0]  height_scale;
      logic [9:0]  max_distance;
      logic [23:0] haze_color;
   } cfg_type;

   // projected sample handed from front to back
   typedef struct packed {
      logic        valid;
      logic        new_frame;
      logic        in_range;
      logic [7:0]  column;
      logic [11:0] row;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
   } front_item_type;

   // one span result
   typedef struct packed {
      logic [7:0]  column;
      logic [11:0] top;
      logic [11:0] length;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
   } span_type;

endpackage

/* rtl/tcsr_ram.sv */
// tcsr_ram: generic single write port ram with registered read
// depends on nothing
module tcsr_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and read-before-write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/tcsr_fifo.sv */
// tcsr_fifo: result queue of span entries, show-ahead output
// depends on tcsr_pkg for span_type
module tcsr_fifo #(
   parameter int DEPTH = tcsr_pkg::OUT_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  tcsr_pkg::span_type push_data,
   input  logic               pop,
   output logic               empty,
   output tcsr_pkg::span_type head
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   tcsr_pkg::span_type slot_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_pop;

   assign empty  = (count_ff == '0);
   assign do_pop = pop && !empty;
   assign head   = slot_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* rtl/tcsr_front.sv */
// tcsr_front: projection and fog pipeline, stateless, one sample per cycle
// depends on tcsr_pkg for cfg_type, front_item_type and row bounds
module tcsr_front #(
   parameter int COLUMNS = tcsr_pkg::COLUMNS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  tcsr_pkg::cfg_type        cfg,
   input  logic                     accept,
   input  logic                     new_frame,
   input  logic [7:0]               column,
   input  logic [13:0]              distance,
   input  logic [7:0]               terrain_height,
   input  logic [7:0]               terrain_red,
   input  logic [7:0]               terrain_green,
   input  logic [7:0]               terrain_blue,
   output tcsr_pkg::front_item_type item
);

   localparam int DIV_STAGES = 11;
   localparam int BLEND_BITS = 8;

   typedef struct packed {
      logic        valid;
      logic        new_frame;
      logic        in_range;
      logic [7:0]  column;
      logic        neg;
      logic        sat;
      logic [13:0] divisor;
      logic [25:0] rem;
      logic [10:0] quo;
      logic [13:0] full;
      logic [22:0] rem_r;
      logic [22:0] rem_g;
      logic [22:0] rem_b;
      logic [7:0]  q_r;
      logic [7:0]  q_g;
      logic [7:0]  q_b;
   } div_type;

   // sample capture with fog weights
   logic [13:0] dist_fix, full_w, fd_w;
   logic [9:0]  maxd;
   logic        p1_valid_ff, p1_new_frame_ff, p1_in_range_ff;
   logic [7:0]  p1_column_ff, p1_height_ff, p1_red_ff, p1_green_ff, p1_blue_ff;
   logic [13:0] p1_dist_ff, p1_fd_ff, p1_gap_ff, p1_full_ff;

   always_comb begin
      dist_fix = (distance == '0) ? 14'd1 : distance;
      maxd     = (cfg.max_distance == '0) ? 10'd1 : cfg.max_distance;
      full_w   = {maxd, 4'b0};
      fd_w     = (dist_fix > full_w) ? full_w : dist_fix;
   end

   always_ff @(posedge clock) begin
      p1_new_frame_ff <= new_frame;
      p1_in_range_ff  <= (int'(column) < COLUMNS);
      p1_column_ff    <= column;
      p1_height_ff    <= terrain_height;
      p1_red_ff       <= terrain_red;
      p1_green_ff     <= terrain_green;
      p1_blue_ff      <= terrain_blue;
      p1_dist_ff      <= dist_fix;
      p1_fd_ff        <= fd_w;
      p1_gap_ff       <= full_w - fd_w;
      p1_full_ff      <= full_w;
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff <= accept;
      end
   end

   // products
   logic signed [12:0] diff;
   logic signed [21:0] prod_a_in;
   logic signed [25:0] prod_b_in;
   logic [21:0] fog_r_in, fog_g_in, fog_b_in, col_r_in, col_g_in, col_b_in;
   logic        p2_valid_ff, p2_new_frame_ff, p2_in_range_ff;
   logic [7:0]  p2_column_ff;
   logic [13:0] p2_dist_ff, p2_full_ff;
   logic signed [21:0] p2_prod_a_ff;
   logic signed [25:0] p2_prod_b_ff;
   logic [21:0] p2_fog_r_ff, p2_fog_g_ff, p2_fog_b_ff;
   logic [21:0] p2_col_r_ff, p2_col_g_ff, p2_col_b_ff;

   always_comb begin
      diff      = $signed({1'b0, cfg.camera_height}) - $signed({5'b0, p1_height_ff});
      prod_a_in = diff * $signed({1'b0, cfg.height_scale});
      prod_b_in = $signed(cfg.horizon_row) * $signed({1'b0, p1_dist_ff});
      fog_r_in  = 22'(cfg.haze_color[23:16]) * 22'(p1_fd_ff);
      fog_g_in  = 22'(cfg.haze_color[15:8]) * 22'(p1_fd_ff);
      fog_b_in  = 22'(cfg.haze_color[7:0]) * 22'(p1_fd_ff);
      col_r_in  = 22'(p1_red_ff) * 22'(p1_gap_ff);
      col_g_in  = 22'(p1_green_ff) * 22'(p1_gap_ff);
      col_b_in  = 22'(p1_blue_ff) * 22'(p1_gap_ff);
   end

   always_ff @(posedge clock) begin
      p2_new_frame_ff <= p1_new_frame_ff;
      p2_in_range_ff  <= p1_in_range_ff;
      p2_column_ff    <= p1_column_ff;
      p2_dist_ff      <= p1_dist_ff;
      p2_full_ff      <= p1_full_ff;
      p2_prod_a_ff    <= prod_a_in;
      p2_prod_b_ff    <= prod_b_in;
      p2_fog_r_ff     <= fog_r_in;
      p2_fog_g_ff     <= fog_g_in;
      p2_fog_b_ff     <= fog_b_in;
      p2_col_r_ff     <= col_r_in;
      p2_col_g_ff     <= col_g_in;
      p2_col_b_ff     <= col_b_in;
      if (reset) begin
         p2_valid_ff <= 1'b0;
      end else begin
         p2_valid_ff <= p1_valid_ff;
      end
   end

   // numerator sums and magnitude
   logic signed [26:0] num;
   logic        p3_valid_ff, p3_new_frame_ff, p3_in_range_ff, p3_neg_ff;
   logic [7:0]  p3_column_ff;
   logic [13:0] p3_dist_ff, p3_full_ff;
   logic [25:0] p3_mag_ff;
   logic [22:0] p3_sum_r_ff, p3_sum_g_ff, p3_sum_b_ff;

   assign num = $signed({p2_prod_a_ff[21], p2_prod_a_ff, 4'b0})
              + $signed({p2_prod_b_ff[25], p2_prod_b_ff});

   always_ff @(posedge clock) begin
      p3_new_frame_ff <= p2_new_frame_ff;
      p3_in_range_ff  <= p2_in_range_ff;
      p3_column_ff    <= p2_column_ff;
      p3_dist_ff      <= p2_dist_ff;
      p3_full_ff      <= p2_full_ff;
      p3_neg_ff       <= num[26];
      p3_mag_ff       <= num[26] ? 26'(-num) : num[25:0];
      p3_sum_r_ff     <= {1'b0, p2_fog_r_ff} + {1'b0, p2_col_r_ff};
      p3_sum_g_ff     <= {1'b0, p2_fog_g_ff} + {1'b0, p2_col_g_ff};
      p3_sum_b_ff     <= {1'b0, p2_fog_b_ff} + {1'b0, p2_col_b_ff};
      if (reset) begin
         p3_valid_ff <= 1'b0;
      end else begin
         p3_valid_ff <= p2_valid_ff;
      end
   end

   // overflow check, seeds the divider chain
   div_type div0_ff;
   div_type seed;

   always_comb begin
      seed           = '0;
      seed.valid     = p3_valid_ff;
      seed.new_frame = p3_new_frame_ff;
      seed.in_range  = p3_in_range_ff;
      seed.column    = p3_column_ff;
      seed.neg       = p3_neg_ff;
      seed.sat       = (p3_mag_ff >= (26'(p3_dist_ff) << DIV_STAGES));
      seed.divisor   = p3_dist_ff;
      seed.rem       = p3_mag_ff;
      seed.full      = p3_full_ff;
      seed.rem_r     = p3_sum_r_ff;
      seed.rem_g     = p3_sum_g_ff;
      seed.rem_b     = p3_sum_b_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div0_ff <= '0;
      end else begin
         div0_ff <= seed;
      end
   end

   // restoring division, one quotient bit per stage
   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
      localparam int QB = DIV_STAGES - 1 - s;

      div_type prev, stage_in, stage_ff;

      if (s == 0) begin : g_first
         assign prev = div0_ff;
      end else begin : g_next
         assign prev = g_div[s - 1].stage_ff;
      end

      always_comb begin
         logic [25:0] dstep;
         logic [22:0] fstep;
         dstep    = 26'(prev.divisor) << QB;
         fstep    = 23'(prev.full) << (QB % BLEND_BITS);
         stage_in = prev;
         if (prev.rem >= dstep) begin
            stage_in.rem     = prev.rem - dstep;
            stage_in.quo[QB] = 1'b1;
         end
         if (QB < BLEND_BITS) begin
            if (prev.rem_r >= fstep) begin
               stage_in.rem_r                = prev.rem_r - fstep;
               stage_in.q_r[QB % BLEND_BITS] = 1'b1;
            end
            if (prev.rem_g >= fstep) begin
               stage_in.rem_g                = prev.rem_g - fstep;
               stage_in.q_g[QB % BLEND_BITS] = 1'b1;
            end
            if (prev.rem_b >= fstep) begin
               stage_in.rem_b                = prev.rem_b - fstep;
               stage_in.q_b[QB % BLEND_BITS] = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            stage_ff <= '0;
         end else begin
            stage_ff <= stage_in;
         end
      end
   end

   // signed, saturated row
   tcsr_pkg::front_item_type item_ff, item_in;
   div_type last;
   logic [11:0] quo_ext;

   always_comb begin
      last              = g_div[DIV_STAGES - 1].stage_ff;
      quo_ext           = {1'b0, last.quo};
      item_in.valid     = last.valid;
      item_in.new_frame = last.new_frame;
      item_in.in_range  = last.in_range;
      item_in.column    = last.column;
      if (last.sat) begin
         item_in.row = last.neg ? tcsr_pkg::ROW_MIN : tcsr_pkg::ROW_MAX;
      end else begin
         item_in.row = last.neg ? (12'd0 - quo_ext) : quo_ext;
      end
      item_in.red   = last.q_r;
      item_in.green = last.q_g;
      item_in.blue  = last.q_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_ff <= '0;
      end else begin
         item_ff <= item_in;
      end
   end

   assign item = item_ff;

endmodule

/* rtl/tcsr_back.sv */
// tcsr_back: per-column occlusion test and update, emits spans
// depends on tcsr_pkg and tcsr_ram
module tcsr_back #(
   parameter int COLUMNS = tcsr_pkg::COLUMNS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [9:0]               screen_height,
   input  tcsr_pkg::front_item_type item,
   output logic                     span_valid,
   output tcsr_pkg::span_type       span,
   output logic                     drop
);

   localparam int AW = $clog2(COLUMNS);

   tcsr_pkg::front_item_type cur_ff;
   logic [COLUMNS-1:0] fresh_ff, fresh_in;
   logic               fwd_valid_ff;
   logic [AW-1:0]      fwd_col_ff;
   logic [11:0]        fwd_row_ff;
   logic [11:0]        ram_rd;
   logic [11:0]        occ;
   logic [AW-1:0]      cur_col;
   logic               cur_fresh;
   logic               emit;

   assign cur_col = AW'(cur_ff.column);

   // occlusion rows, read in the cycle before the test
   tcsr_ram #(
      .WIDTH (12),
      .DEPTH (COLUMNS)
   ) u_occ_ram (
      .clock   (clock),
      .wr_en   (emit),
      .wr_addr (cur_col),
      .wr_data (cur_ff.row),
      .rd_addr (AW'(item.column)),
      .rd_data (ram_rd)
   );

   // occlusion test with bypass of the previous write
   always_comb begin
      cur_fresh = cur_ff.new_frame || fresh_ff[cur_col];
      if (cur_fresh) begin
         occ = {2'b0, screen_height};
      end else if (fwd_valid_ff && fwd_col_ff == cur_col) begin
         occ = fwd_row_ff;
      end else begin
         occ = ram_rd;
      end
      emit = cur_ff.valid && cur_ff.in_range && ($signed(cur_ff.row) < $signed(occ));
   end

   // fresh flags: new frame sets all, a write clears one
   always_comb begin
      fresh_in = fresh_ff;
      if (cur_ff.valid && cur_ff.new_frame) begin
         fresh_in = '1;
      end
      if (emit) begin
         fresh_in[cur_col] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      fwd_col_ff <= cur_col;
      fwd_row_ff <= cur_ff.row;
      if (reset) begin
         cur_ff       <= '0;
         fresh_ff     <= '1;
         fwd_valid_ff <= 1'b0;
      end else begin
         cur_ff       <= item;
         fresh_ff     <= fresh_in;
         fwd_valid_ff <= emit;
      end
   end

   // span output
   assign span_valid  = emit;
   assign drop        = cur_ff.valid && !emit;
   assign span.column = cur_ff.column;
   assign span.top    = cur_ff.row;
   assign span.length = occ - cur_ff.row;
   assign span.red    = cur_ff.red;
   assign span.green  = cur_ff.green;
   assign span.blue   = cur_ff.blue;

endmodule

/* rtl/terrain_column_span_renderer.sv */
// terrain_column_span_renderer: top level, registers, credit count, result queue
// depends on tcsr_pkg, tcsr_front, tcsr_back, tcsr_fifo
//
//   channel  ports                          handshake
//   request  push, full, req_*              accepted when push && !full
//   result   empty, pop, rsp_*              taken when pop && !empty
//   csr      csr_write_en, csr_index, ...   written when csr_write_en
//
// one request per cycle while full is low; a request passes through
// four front stages, eleven divider stages, output and occlusion stage
// full rises when requests in flight plus queued spans reach OUT_DEPTH
// reset is synchronous; occlusion rows need no clearing pass, fresh flags cover them
module terrain_column_span_renderer #(
   parameter int COLUMNS   = tcsr_pkg::COLUMNS_DEFAULT,
   parameter int OUT_DEPTH = tcsr_pkg::OUT_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic        req_new_frame,
   input  logic [7:0]  req_column,
   input  logic [13:0] req_distance,
   input  logic [7:0]  req_terrain_height,
   input  logic [7:0]  req_terrain_red,
   input  logic [7:0]  req_terrain_green,
   input  logic [7:0]  req_terrain_blue,
   output logic        empty,
   input  logic        pop,
   output logic [7:0]  rsp_span_column,
   output logic [11:0] rsp_span_top,
   output logic [11:0] rsp_span_length,
   output logic [7:0]  rsp_span_red,
   output logic [7:0]  rsp_span_green,
   output logic [7:0]  rsp_span_blue,
   input  logic        csr_write_en,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_data
);

   localparam int CW = $clog2(OUT_DEPTH + 1);

   tcsr_pkg::cfg_type        cfg_ff, cfg_in;
   tcsr_pkg::front_item_type front_item;
   tcsr_pkg::span_type       span, head;
   logic                     span_valid, drop, accept, do_pop;
   logic [CW-1:0]            credit_ff, credit_in;

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            tcsr_pkg::CSR_CAMERA_HEIGHT: cfg_in.camera_height = csr_data[11:0];
            tcsr_pkg::CSR_HORIZON_ROW:   cfg_in.horizon_row   = csr_data[10:0];
            tcsr_pkg::CSR_SCREEN_HEIGHT: cfg_in.screen_height = csr_data[9:0];
            tcsr_pkg::CSR_HEIGHT_SCALE:  cfg_in.height_scale  = csr_data[7:0];
            tcsr_pkg::CSR_MAX_DISTANCE:  cfg_in.max_distance  = csr_data[9:0];
            tcsr_pkg::CSR_HAZE_COLOR:    cfg_in.haze_color    = csr_data;
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.camera_height <= tcsr_pkg::CAMERA_HEIGHT_RESET;
         cfg_ff.horizon_row   <= tcsr_pkg::HORIZON_ROW_RESET;
         cfg_ff.screen_height <= tcsr_pkg::SCREEN_HEIGHT_RESET;
         cfg_ff.height_scale  <= tcsr_pkg::HEIGHT_SCALE_RESET;
         cfg_ff.max_distance  <= tcsr_pkg::MAX_DISTANCE_RESET;
         cfg_ff.haze_color    <= tcsr_pkg::HAZE_COLOR_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // credits: requests in flight plus queued spans
   assign full   = (credit_ff == CW'(OUT_DEPTH));
   assign accept = push && !full;
   assign do_pop = pop && !empty;

   always_comb begin
      credit_in = credit_ff;
      if (accept) begin
         credit_in = credit_in + 1'b1;
      end
      if (do_pop) begin
         credit_in = credit_in - 1'b1;
      end
      if (drop) begin
         credit_in = credit_in - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff <= '0;
      end else begin
         credit_ff <= credit_in;
      end
   end

   // projection front
   tcsr_front #(
      .COLUMNS (COLUMNS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .accept         (accept),
      .new_frame      (req_new_frame),
      .column         (req_column),
      .distance       (req_distance),
      .terrain_height (req_terrain_height),
      .terrain_red    (req_terrain_red),
      .terrain_green  (req_terrain_green),
      .terrain_blue   (req_terrain_blue),
      .item           (front_item)
   );

   // occlusion back
   tcsr_back #(
      .COLUMNS (COLUMNS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .screen_height (cfg_ff.screen_height),
      .item          (front_item),
      .span_valid    (span_valid),
      .span          (span),
      .drop          (drop)
   );

   // result queue
   tcsr_fifo #(
      .DEPTH (OUT_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (span_valid),
      .push_data (span),
      .pop       (pop),
      .empty     (empty),
      .head      (head)
   );

   assign rsp_span_column = head.column;
   assign rsp_span_top    = head.top;
   assign rsp_span_length = head.length;
   assign rsp_span_red    = head.red;
   assign rsp_span_green  = head.green;
   assign rsp_span_blue   = head.blue;

endmodule

/* bench/tb_terrain_column_span_renderer.sv */
// tb_terrain_column_span_renderer: self-checking bench for the terrain column span renderer
// depends on tcsr_pkg and terrain_column_span_renderer; predicts spans and checks each one
module tb_terrain_column_span_renderer;

   localparam int NCOL = 256;
   localparam int SETTLE = 40;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   logic        req_new_frame = 1'b0;
   logic [7:0]  req_column = '0;
   logic [13:0] req_distance = '0;
   logic [7:0]  req_terrain_height = '0;
   logic [7:0]  req_terrain_red = '0;
   logic [7:0]  req_terrain_green = '0;
   logic [7:0]  req_terrain_blue = '0;
   logic        empty;
   logic        pop = 1'b0;
   logic [7:0]  rsp_span_column;
   logic [11:0] rsp_span_top;
   logic [11:0] rsp_span_length;
   logic [7:0]  rsp_span_red;
   logic [7:0]  rsp_span_green;
   logic [7:0]  rsp_span_blue;
   logic        csr_write_en = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [23:0] csr_data = '0;

   terrain_column_span_renderer i_dut (.*);

   // clock
   initial begin
      forever #5 clock = ~clock;
   end

   // predictor state
   tcsr_pkg::cfg_type  cfg;
   logic [11:0]        occ_row [NCOL];
   bit                 fresh [NCOL];
   tcsr_pkg::span_type span_queue [$];
   int                 errors = 0;
   int                 send_idle = 0;
   int                 take_idle = 0;

   // project one request and queue the span it causes, if any
   task automatic predict_span(input bit nf, input logic [7:0] col, input logic [13:0] dist_in,
                               input logic [7:0] hgt, input logic [7:0] r, input logic [7:0] g,
                               input logic [7:0] b);
      longint ray_d, num, row, occ, full_d, fd;
      tcsr_pkg::span_type s;
      if (nf) foreach (fresh[i]) fresh[i] = 1;
      ray_d = (dist_in == 0) ? 1 : dist_in;
      num = (longint'(cfg.camera_height) - longint'(hgt)) * longint'(cfg.height_scale) * 16
            + longint'($signed(cfg.horizon_row)) * ray_d;
      row = num / ray_d;
      if (row < -2048) row = -2048;
      if (row > 2047) row = 2047;
      occ = fresh[col] ? longint'(cfg.screen_height) : longint'($signed(occ_row[col]));
      if (row < occ) begin
         occ_row[col] = row[11:0];
         fresh[col] = 0;
         full_d = ((cfg.max_distance == 0) ? 1 : longint'(cfg.max_distance)) * 16;
         fd = (ray_d > full_d) ? full_d : ray_d;
         s.column = col;
         s.top = row[11:0];
         s.length = 12'(occ - row);
         s.red = 8'((longint'(cfg.haze_color[23:16]) * fd + longint'(r) * (full_d - fd))
                    / full_d);
         s.green = 8'((longint'(cfg.haze_color[15:8]) * fd + longint'(g) * (full_d - fd))
                      / full_d);
         s.blue = 8'((longint'(cfg.haze_color[7:0]) * fd + longint'(b) * (full_d - fd))
                     / full_d);
         span_queue.push_back(s);
      end
   endtask

   // send one request, predicting at acceptance; push stays high for the next one
   task automatic send_request(input bit nf, input logic [7:0] col, input logic [13:0] ray_dist,
                               input logic [7:0] hgt, input logic [7:0] r, input logic [7:0] g,
                               input logic [7:0] b);
      while ($urandom_range(99) < send_idle) begin
         push <= 1'b0;
         @(negedge clock);
      end
      push <= 1'b1;
      req_new_frame <= nf;
      req_column <= col;
      req_distance <= ray_dist;
      req_terrain_height <= hgt;
      req_terrain_red <= r;
      req_terrain_green <= g;
      req_terrain_blue <= b;
      do @(posedge clock); while (full);
      predict_span(nf, col, ray_dist, hgt, r, g, b);
      @(negedge clock);
   endtask

   task automatic send_random(input int dist_max);
      send_request($urandom_range(99) < 3, 8'($urandom), 14'($urandom_range(dist_max)),
                   8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
   endtask

   // stop sending, wait for all spans, then for the pipeline to drain
   task automatic drain();
      int guard = 0;
      push <= 1'b0;
      while (span_queue.size() != 0 && guard < 100000) begin
         @(negedge clock);
         guard++;
      end
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(negedge clock);
      case (idx)
         tcsr_pkg::CSR_CAMERA_HEIGHT: cfg.camera_height = val[11:0];
         tcsr_pkg::CSR_HORIZON_ROW:   cfg.horizon_row = val[10:0];
         tcsr_pkg::CSR_SCREEN_HEIGHT: cfg.screen_height = val[9:0];
         tcsr_pkg::CSR_HEIGHT_SCALE:  cfg.height_scale = val[7:0];
         tcsr_pkg::CSR_MAX_DISTANCE:  cfg.max_distance = val[9:0];
         tcsr_pkg::CSR_HAZE_COLOR:    cfg.haze_color = val;
         default: ;
      endcase
   endtask

   task automatic write_all(input logic [11:0] cam, input logic [10:0] hor,
                            input logic [9:0] scr, input logic [7:0] scl,
                            input logic [9:0] maxd, input logic [23:0] haze);
      drain();
      write_reg(tcsr_pkg::CSR_CAMERA_HEIGHT, 24'(cam));
      write_reg(tcsr_pkg::CSR_HORIZON_ROW, 24'(hor));
      write_reg(tcsr_pkg::CSR_SCREEN_HEIGHT, 24'(scr));
      write_reg(tcsr_pkg::CSR_HEIGHT_SCALE, 24'(scl));
      write_reg(tcsr_pkg::CSR_MAX_DISTANCE, 24'(maxd));
      write_reg(tcsr_pkg::CSR_HAZE_COLOR, haze);
      csr_write_en <= 1'b0;
   endtask

   // directed: field extremes, saturation, fog, occlusion and new frame
   task automatic test_directed();
      send_request(1, 8'd0, 14'd16, 8'd0, 8'd255, 8'd0, 8'd128);
      send_request(0, 8'd255, 14'd16383, 8'd255, 8'd0, 8'd255, 8'd1);
      send_request(0, 8'd5, 14'd0, 8'd0, 8'd10, 8'd20, 8'd30);
      send_request(0, 8'd5, 14'd1, 8'd255, 8'd10, 8'd20, 8'd30);
      send_request(0, 8'd0, 14'd100, 8'd10, 8'd1, 8'd2, 8'd3);
      send_request(1, 8'd0, 14'd6400, 8'd0, 8'd1, 8'd2, 8'd3);
      write_all(12'd4095, 11'h400, 10'd1023, 8'd255, 10'd1, 24'hFFFFFF);
      send_request(1, 8'd7, 14'd1, 8'd0, 8'd200, 8'd100, 8'd50);
      send_request(0, 8'd8, 14'd16383, 8'd255, 8'd200, 8'd100, 8'd50);
      write_all(12'd0, 11'h3FF, 10'd0, 8'd255, 10'd0, 24'h000000);
      send_request(1, 8'd9, 14'd1, 8'd255, 8'd255, 8'd255, 8'd255);
      send_request(0, 8'd9, 14'd2, 8'd255, 8'd255, 8'd255, 8'd255);
      write_all(12'd200, 11'd120, 10'd240, 8'd1, 10'd1023, 24'h123456);
      send_request(1, 8'd3, 14'd16, 8'd0, 8'd9, 8'd9, 8'd9);
      send_request(0, 8'd3, 14'd16, 8'd0, 8'd9, 8'd9, 8'd9);
   endtask

   // random spans under a mix of settings
   task automatic test_random(input int count);
      for (int i = 0; i < count; i++) begin
         if (i % 100 == 0) begin
            write_all(12'($urandom_range(600)), 11'($urandom_range(2047)),
                      10'($urandom_range(1023)), 8'($urandom_range(255)),
                      10'($urandom_range(1023)), 24'($urandom));
         end
         send_random((i % 4 == 0) ? 16383 : 2000);
      end
   endtask

   // result checker with random stalls
   always @(posedge clock) begin
      if (!reset && pop && !empty) begin
         if (span_queue.size() == 0) begin
            $error("span with none expected: column %0d", rsp_span_column);
            errors++;
         end else begin
            tcsr_pkg::span_type s;
            s = span_queue.pop_front();
            if (rsp_span_column !== s.column) begin
               $error("span_column expected %0d got %0d", s.column, rsp_span_column);
               errors++;
            end
            if (rsp_span_top !== s.top) begin
               $error("span_top expected %0d got %0d", s.top, rsp_span_top);
               errors++;
            end
            if (rsp_span_length !== s.length) begin
               $error("span_length expected %0d got %0d", s.length, rsp_span_length);
               errors++;
            end
            if (rsp_span_red !== s.red) begin
               $error("span_red expected %0d got %0d", s.red, rsp_span_red);
               errors++;
            end
            if (rsp_span_green !== s.green) begin
               $error("span_green expected %0d got %0d", s.green, rsp_span_green);
               errors++;
            end
            if (rsp_span_blue !== s.blue) begin
               $error("span_blue expected %0d got %0d", s.blue, rsp_span_blue);
               errors++;
            end
         end
      end
   end

   always @(negedge clock) begin
      pop <= ($urandom_range(99) >= take_idle);
   end

   // main sequence
   initial begin
      cfg.camera_height = tcsr_pkg::CAMERA_HEIGHT_RESET;
      cfg.horizon_row = tcsr_pkg::HORIZON_ROW_RESET;
      cfg.screen_height = tcsr_pkg::SCREEN_HEIGHT_RESET;
      cfg.height_scale = tcsr_pkg::HEIGHT_SCALE_RESET;
      cfg.max_distance = tcsr_pkg::MAX_DISTANCE_RESET;
      cfg.haze_color = tcsr_pkg::HAZE_COLOR_RESET;
      foreach (fresh[i]) begin
         fresh[i] = 1;
         occ_row[i] = '0;
      end
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      send_idle = 14;
      take_idle = 74;
      test_directed();
      test_random(500);
      send_idle = 74;
      take_idle = 14;
      test_random(500);
      send_idle = 0;
      take_idle = 0;
      test_random(500);
      drain();
      if (span_queue.size() == 0 && errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // timeout
   initial begin
      #5000000;
      $display("TB_ERROR");
      $finish;
   end

endmodule

/* filelist.f */
rtl/tcsr_pkg.sv
rtl/tcsr_ram.sv
rtl/tcsr_fifo.sv
rtl/tcsr_front.sv
rtl/tcsr_back.sv
rtl/terrain_column_span_renderer.sv
bench/tb_terrain_column_span_renderer.sv
